// ===== hw/rtl/fem_force_apply_2d_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fem_force_apply_2d block
// Implication checks, same cycle and next cycle, held off during reset.
// ---------------------------------------------------------------------------
`ifndef FEM_FORCE_APPLY_2D_ASSERT_SVH
`define FEM_FORCE_APPLY_2D_ASSERT_SVH

`ifndef ASSERT_OFF
`define FFA_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFA_ASSERT(lbl, clk, rstn, ante, cons)
`define FFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/fem_fa_pkg.sv =====
// ---------------------------------------------------------------------------
// fem_fa_pkg
// Shared types, codes and saturation helpers of the force operator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fem_fa_pkg;

    localparam int QUAD_POINTS_DEF = 4;
    localparam int L2_DOFS_DEF     = 2;
    localparam int H1_DOFS_DEF     = 3;
    localparam int SPACE_DIMS      = 2;
    localparam int ACC_W           = 48;
    localparam int VAL_W           = 32;
    localparam int IDX_W           = 3;

    typedef enum logic [2:0] {
        REQ_L2      = 3'd0,
        REQ_H1      = 3'd1,
        REQ_DH1     = 3'd2,
        REQ_EDOF    = 3'd3,
        REQ_STRESS  = 3'd4,
        REQ_COMPUTE = 3'd5
    } t_req;

    typedef enum logic [9:0] {
        K_IDLE = 10'b00_0000_0001,
        K_EX   = 10'b00_0000_0010,
        K_QE   = 10'b00_0000_0100,
        K_ESX  = 10'b00_0000_1000,
        K_ESY  = 10'b00_0001_0000,
        K_RPD  = 10'b00_0010_0000,
        K_RPV  = 10'b00_0100_0000,
        K_FY   = 10'b00_1000_0000,
        K_FD   = 10'b01_0000_0000,
        K_OUT  = 10'b10_0000_0000
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             first;
        logic             last;
        logic             comp;
        logic [IDX_W-1:0] qx;
        logic [IDX_W-1:0] qy;
        logic [IDX_W-1:0] dx;
        logic [IDX_W-1:0] dy;
    } t_step;

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd140737488355327;
        lo = -66'sd140737488355328;
        if (x > hi) begin
            return hi[ACC_W-1:0];
        end else if (x < lo) begin
            return lo[ACC_W-1:0];
        end
        return x[ACC_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 48'sd2147483647;
        lo = -48'sd2147483648;
        if (x > hi) begin
            return hi[VAL_W-1:0];
        end else if (x < lo) begin
            return lo[VAL_W-1:0];
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/fem_fa_mac.sv =====
// ---------------------------------------------------------------------------
// fem_fa_mac
// Shared multiply-accumulate unit: acc + round(a * b / 2^16), saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fem_fa_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [fem_fa_pkg::ACC_W-1:0]   i_a,
    input  logic signed [fem_fa_pkg::VAL_W-1:0]   i_b,
    input  logic signed [fem_fa_pkg::ACC_W-1:0]   i_acc,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic signed [fem_fa_pkg::ACC_W-1:0]   o_res
);

    logic [3:0]                                r_stg;
    logic                                      r_done;
    logic signed [fem_fa_pkg::ACC_W-1:0]       r_a;
    logic signed [fem_fa_pkg::VAL_W-1:0]       r_b;
    logic signed [fem_fa_pkg::ACC_W-1:0]       r_acc;
    logic signed [63:0]                        r_ph;
    logic signed [49:0]                        r_pl;
    logic signed [fem_fa_pkg::ACC_W-1:0]       r_prod;
    logic signed [fem_fa_pkg::ACC_W-1:0]       r_res;
    logic signed [32:0]                        m_x;
    logic signed [64:0]                        m_prod;

    // high half (floor of a/2^16) first, then the low 16 bits unsigned
    assign m_x    = r_stg[0] ? 33'($signed(r_a[47:16])) : $signed({17'b0, r_a[15:0]});
    assign m_prod = m_x * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= '0;
            r_done <= 1'b0;
        end else begin
            r_stg  <= {r_stg[2:0], i_start};
            r_done <= r_stg[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= i_acc;
        end
        if (r_stg[0]) begin
            r_ph <= m_prod[63:0];
        end
        if (r_stg[1]) begin
            r_pl <= m_prod[49:0] + 50'sd32768;
        end
        if (r_stg[2]) begin
            r_prod <= fem_fa_pkg::sat48(66'(r_ph) + 66'(r_pl >>> 16));
        end
        if (r_stg[3]) begin
            r_res <= fem_fa_pkg::sat48(66'(r_acc) + 66'(r_prod));
        end
    end

    assign o_busy = (|r_stg) | r_done;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hw/rtl/fem_fa_seq.sv =====
// ---------------------------------------------------------------------------
// fem_fa_seq
// Loop sequencer: walks interpolation, scaling, contraction and emit steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fem_fa_seq #(
    parameter int QUAD_POINTS = fem_fa_pkg::QUAD_POINTS_DEF,
    parameter int L2_DOFS     = fem_fa_pkg::L2_DOFS_DEF,
    parameter int H1_DOFS     = fem_fa_pkg::H1_DOFS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_advance,
    output fem_fa_pkg::t_step o_step
);

    localparam int QW = (QUAD_POINTS > 1) ? $clog2(QUAD_POINTS) : 1;
    localparam int LW = (L2_DOFS > 1) ? $clog2(L2_DOFS) : 1;
    localparam int HW = (H1_DOFS > 1) ? $clog2(H1_DOFS) : 1;
    localparam int DW = (LW > HW) ? LW : HW;
    localparam logic [QW-1:0] Q_LAST = QW'(QUAD_POINTS - 1);
    localparam logic [DW-1:0] L_LAST = DW'(L2_DOFS - 1);
    localparam logic [DW-1:0] H_LAST = DW'(H1_DOFS - 1);

    fem_fa_pkg::t_kind r_kind, n_kind;
    logic              r_c, n_c;
    logic [QW-1:0]     r_qx, n_qx, r_qy, n_qy;
    logic [DW-1:0]     r_dx, n_dx, r_dy, n_dy;
    logic              first;

    always_comb begin
        n_kind = r_kind;
        n_c    = r_c;
        n_qx   = r_qx;
        n_qy   = r_qy;
        n_dx   = r_dx;
        n_dy   = r_dy;
        unique case (r_kind)
            fem_fa_pkg::K_IDLE: begin
                if (i_start) begin
                    n_kind = fem_fa_pkg::K_EX;
                    n_c    = 1'b0;
                    n_qx   = '0;
                    n_qy   = '0;
                    n_dx   = '0;
                    n_dy   = '0;
                end
            end
            fem_fa_pkg::K_EX: begin
                if (i_advance) begin
                    if (r_qx == Q_LAST) begin
                        n_qx = '0;
                        if (r_dx == L_LAST) begin
                            n_dx   = '0;
                            n_qy   = '0;
                            n_kind = fem_fa_pkg::K_QE;
                        end else begin
                            n_dx = r_dx + 1'b1;
                        end
                    end else begin
                        n_qx = r_qx + 1'b1;
                    end
                end
            end
            fem_fa_pkg::K_QE: begin
                if (i_advance) begin
                    if (r_qx == Q_LAST) begin
                        n_qx = '0;
                        if (r_qy == Q_LAST) begin
                            n_qy = '0;
                            if (r_dy == L_LAST) begin
                                n_dy   = '0;
                                n_c    = 1'b0;
                                n_kind = fem_fa_pkg::K_ESX;
                            end else begin
                                n_dy   = r_dy + 1'b1;
                                n_kind = fem_fa_pkg::K_EX;
                            end
                        end else begin
                            n_qy = r_qy + 1'b1;
                        end
                    end else begin
                        n_qx = r_qx + 1'b1;
                    end
                end
            end
            fem_fa_pkg::K_ESX: begin
                if (i_advance) begin
                    n_kind = fem_fa_pkg::K_ESY;
                end
            end
            fem_fa_pkg::K_ESY: begin
                if (i_advance) begin
                    n_kind = fem_fa_pkg::K_RPD;
                end
            end
            fem_fa_pkg::K_RPD: begin
                if (i_advance) begin
                    n_kind = fem_fa_pkg::K_RPV;
                end
            end
            fem_fa_pkg::K_RPV: begin
                if (i_advance) begin
                    if (r_dx == H_LAST) begin
                        n_dx = '0;
                        if (r_qx == Q_LAST) begin
                            n_qx   = '0;
                            n_dy   = '0;
                            n_kind = fem_fa_pkg::K_FY;
                        end else begin
                            n_qx   = r_qx + 1'b1;
                            n_kind = fem_fa_pkg::K_ESX;
                        end
                    end else begin
                        n_dx   = r_dx + 1'b1;
                        n_kind = fem_fa_pkg::K_RPD;
                    end
                end
            end
            fem_fa_pkg::K_FY: begin
                if (i_advance) begin
                    n_kind = fem_fa_pkg::K_FD;
                end
            end
            fem_fa_pkg::K_FD: begin
                if (i_advance) begin
                    n_kind = fem_fa_pkg::K_FY;
                    if (r_dx == H_LAST) begin
                        n_dx = '0;
                        if (r_dy == H_LAST) begin
                            n_dy = '0;
                            if (r_qy == Q_LAST) begin
                                n_qy = '0;
                                if (r_c) begin
                                    n_c    = 1'b0;
                                    n_kind = fem_fa_pkg::K_OUT;
                                end else begin
                                    n_c    = 1'b1;
                                    n_kind = fem_fa_pkg::K_ESX;
                                end
                            end else begin
                                n_qy   = r_qy + 1'b1;
                                n_kind = fem_fa_pkg::K_ESX;
                            end
                        end else begin
                            n_dy = r_dy + 1'b1;
                        end
                    end else begin
                        n_dx = r_dx + 1'b1;
                    end
                end
            end
            fem_fa_pkg::K_OUT: begin
                if (i_advance) begin
                    if (r_dx == H_LAST) begin
                        n_dx = '0;
                        if (r_dy == H_LAST) begin
                            n_dy = '0;
                            if (r_c) begin
                                n_c    = 1'b0;
                                n_kind = fem_fa_pkg::K_IDLE;
                            end else begin
                                n_c = 1'b1;
                            end
                        end else begin
                            n_dy = r_dy + 1'b1;
                        end
                    end else begin
                        n_dx = r_dx + 1'b1;
                    end
                end
            end
            default: begin
                n_kind = fem_fa_pkg::K_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= fem_fa_pkg::K_IDLE;
            r_c    <= 1'b0;
            r_qx   <= '0;
            r_qy   <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
        end else begin
            r_kind <= n_kind;
            r_c    <= n_c;
            r_qx   <= n_qx;
            r_qy   <= n_qy;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
        end
    end

    // accumulator starts from zero on the first term of each sum
    always_comb begin
        case (r_kind)
            fem_fa_pkg::K_EX:  first = (r_dx == '0);
            fem_fa_pkg::K_QE:  first = (r_dy == '0);
            fem_fa_pkg::K_ESX: first = 1'b1;
            fem_fa_pkg::K_ESY: first = 1'b1;
            fem_fa_pkg::K_RPD: first = (r_qx == '0);
            fem_fa_pkg::K_RPV: first = (r_qx == '0);
            fem_fa_pkg::K_FY:  first = (r_qy == '0);
            default:           first = 1'b0;
        endcase
    end

    assign o_step.kind  = r_kind;
    assign o_step.first = first;
    assign o_step.last  = r_c && (r_dy == H_LAST) && (r_dx == H_LAST);
    assign o_step.comp  = r_c;
    assign o_step.qx    = fem_fa_pkg::IDX_W'(r_qx);
    assign o_step.qy    = fem_fa_pkg::IDX_W'(r_qy);
    assign o_step.dx    = fem_fa_pkg::IDX_W'(r_dx);
    assign o_step.dy    = fem_fa_pkg::IDX_W'(r_dy);

endmodule

// ===== hw/rtl/fem_force_apply_2d.sv =====
// ---------------------------------------------------------------------------
// fem_force_apply_2d
// 2D sum-factorized force operator: table loads, then per-element compute
// through one shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                              tuser      tlast
// s_axis   in   index_a[3] index_b[3] row[1] col[1] value[32]   req_type   -
// m_axis   out  dof_x[3] dof_y[3] force_value[32] pad[2]        component  last
//
// Load items are accepted only while idle. A compute item runs Q=QUAD_POINTS,
// L=L2_DOFS, H=H1_DOFS: N = L*(L*Q+Q*Q) + 2*Q*(Q*(2+2*H)+2*H*H) multiply-
// accumulates, each as operand read (FETCH), issue (EXEC) and MAC wait (WAIT),
// then 2*H*H results. Every multiply-accumulate goes through the single MAC.
// s_axis_tready is low for the whole compute. Emit stalls on m_axis_tready.
// Reset clears control only; tables are undefined until loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fem_force_apply_2d_assert.svh"

module fem_force_apply_2d #(
    parameter int QUAD_POINTS = fem_fa_pkg::QUAD_POINTS_DEF,
    parameter int L2_DOFS     = fem_fa_pkg::L2_DOFS_DEF,
    parameter int H1_DOFS     = fem_fa_pkg::H1_DOFS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // index_a, index_b, stress_row, stress_col, load_value
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // dof_x, dof_y, force_value, zero pad
    output logic [0:0]  m_axis_tuser,   // component
    output logic        m_axis_tlast
);

    localparam int QW = (QUAD_POINTS > 1) ? $clog2(QUAD_POINTS) : 1;
    localparam int LW = (L2_DOFS > 1) ? $clog2(L2_DOFS) : 1;
    localparam int HW = (H1_DOFS > 1) ? $clog2(H1_DOFS) : 1;
    localparam int AW = fem_fa_pkg::ACC_W;
    localparam int VW = fem_fa_pkg::VAL_W;
    localparam int SD = fem_fa_pkg::SPACE_DIMS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // tables
    logic signed [VW-1:0] r_l2     [QUAD_POINTS][L2_DOFS];
    logic signed [VW-1:0] r_h1     [QUAD_POINTS][H1_DOFS];
    logic signed [VW-1:0] r_dh1    [QUAD_POINTS][H1_DOFS];
    logic signed [VW-1:0] r_edof   [L2_DOFS][L2_DOFS];
    logic signed [VW-1:0] r_stress [SD][SD][QUAD_POINTS][QUAD_POINTS];
    // working stores
    logic signed [AW-1:0] r_ex     [QUAD_POINTS];
    logic signed [AW-1:0] r_qe     [QUAD_POINTS][QUAD_POINTS];
    logic signed [AW-1:0] r_rp     [2][H1_DOFS];
    logic signed [AW-1:0] r_acc    [SD][H1_DOFS][H1_DOFS];
    logic signed [AW-1:0] r_esx, r_esy;

    logic signed [VW-1:0] r_l2_rd, r_h1_rd, r_dh1_rd, r_edof_rd, r_st_rd;
    logic signed [AW-1:0] r_ex_rd, r_qe_rd, r_rp_rd, r_acc_rd;

    logic                 r_out_valid;
    logic [2:0]           r_out_dx, r_out_dy;
    logic signed [VW-1:0] r_out_force;
    logic                 r_out_comp, r_out_last;

    fem_fa_pkg::t_step    step;
    logic                 seq_start, seq_advance;
    logic                 mac_start, mac_busy, mac_done;
    logic signed [AW-1:0] mac_a, mac_acc, mac_res;
    logic signed [VW-1:0] mac_b;

    logic                 in_acc;
    logic [2:0]           in_ia, in_ib;
    logic                 in_row, in_col;
    logic signed [VW-1:0] in_val;
    logic                 out_load;

    logic [QW-1:0]        l2_aq, h1_aq, dh1_aq;
    logic [LW-1:0]        l2_ad;
    logic [HW-1:0]        h1_ad, dh1_ad;
    logic                 rp_sel, st_row;
    logic                 wb;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_ia  = s_axis_tdata[2:0];
    assign in_ib  = s_axis_tdata[5:3];
    assign in_row = s_axis_tdata[6];
    assign in_col = s_axis_tdata[7];
    assign in_val = s_axis_tdata[39:8];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);
    assign seq_start     = in_acc && (fem_fa_pkg::t_req'(s_axis_tuser) == fem_fa_pkg::REQ_COMPUTE);
    assign seq_advance   = ((r_state == ST_WAIT) && mac_done) || out_load;
    assign mac_start     = (r_state == ST_EXEC);
    assign wb            = (r_state == ST_WAIT) && mac_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (seq_start) n_state = ST_FETCH;
            ST_FETCH: n_state = (step.kind == fem_fa_pkg::K_OUT) ? ST_OUT : ST_EXEC;
            ST_EXEC:  n_state = ST_WAIT;
            ST_WAIT:  if (mac_done) n_state = ST_FETCH;
            ST_OUT: begin
                if (out_load) begin
                    n_state = step.last ? ST_IDLE : ST_FETCH;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table loads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            case (fem_fa_pkg::t_req'(s_axis_tuser))
                fem_fa_pkg::REQ_L2: begin
                    if (32'(in_ia) < QUAD_POINTS && 32'(in_ib) < L2_DOFS) begin
                        r_l2[in_ia[QW-1:0]][in_ib[LW-1:0]] <= in_val;
                    end
                end
                fem_fa_pkg::REQ_H1: begin
                    if (32'(in_ia) < QUAD_POINTS && 32'(in_ib) < H1_DOFS) begin
                        r_h1[in_ia[QW-1:0]][in_ib[HW-1:0]] <= in_val;
                    end
                end
                fem_fa_pkg::REQ_DH1: begin
                    if (32'(in_ia) < QUAD_POINTS && 32'(in_ib) < H1_DOFS) begin
                        r_dh1[in_ia[QW-1:0]][in_ib[HW-1:0]] <= in_val;
                    end
                end
                fem_fa_pkg::REQ_EDOF: begin
                    if (32'(in_ia) < L2_DOFS && 32'(in_ib) < L2_DOFS) begin
                        r_edof[in_ia[LW-1:0]][in_ib[LW-1:0]] <= in_val;
                    end
                end
                fem_fa_pkg::REQ_STRESS: begin
                    if (32'(in_ia) < QUAD_POINTS && 32'(in_ib) < QUAD_POINTS) begin
                        r_stress[in_row][in_col][in_ia[QW-1:0]][in_ib[QW-1:0]] <= in_val;
                    end
                end
                default: ;
            endcase
        end
    end

    // read addresses
    always_comb begin
        l2_aq  = step.qx[QW-1:0];
        l2_ad  = step.dx[LW-1:0];
        h1_aq  = step.qx[QW-1:0];
        h1_ad  = step.dx[HW-1:0];
        dh1_aq = step.qx[QW-1:0];
        dh1_ad = step.dx[HW-1:0];
        case (step.kind)
            fem_fa_pkg::K_QE: begin
                l2_aq = step.qy[QW-1:0];
                l2_ad = step.dy[LW-1:0];
            end
            fem_fa_pkg::K_FY: begin
                h1_aq = step.qy[QW-1:0];
                h1_ad = step.dy[HW-1:0];
            end
            fem_fa_pkg::K_FD: begin
                dh1_aq = step.qy[QW-1:0];
                dh1_ad = step.dy[HW-1:0];
            end
            default: ;
        endcase
    end

    assign rp_sel = (step.kind == fem_fa_pkg::K_RPV) || (step.kind == fem_fa_pkg::K_FD);
    assign st_row = (step.kind == fem_fa_pkg::K_ESY);

    always_ff @(posedge i_clk) begin
        r_l2_rd   <= r_l2[l2_aq][l2_ad];
        r_h1_rd   <= r_h1[h1_aq][h1_ad];
        r_dh1_rd  <= r_dh1[dh1_aq][dh1_ad];
        r_edof_rd <= r_edof[step.dx[LW-1:0]][step.dy[LW-1:0]];
        r_st_rd   <= r_stress[st_row][step.comp][step.qx[QW-1:0]][step.qy[QW-1:0]];
        r_ex_rd   <= r_ex[step.qx[QW-1:0]];
        r_qe_rd   <= r_qe[step.qx[QW-1:0]][step.qy[QW-1:0]];
        r_rp_rd   <= r_rp[rp_sel][step.dx[HW-1:0]];
        r_acc_rd  <= r_acc[step.comp][step.dy[HW-1:0]][step.dx[HW-1:0]];
    end

    // operand select
    always_comb begin
        mac_a   = r_rp_rd;
        mac_b   = r_h1_rd;
        mac_acc = r_acc_rd;
        case (step.kind)
            fem_fa_pkg::K_EX: begin
                mac_a   = AW'(r_edof_rd);
                mac_b   = r_l2_rd;
                mac_acc = r_ex_rd;
            end
            fem_fa_pkg::K_QE: begin
                mac_a   = r_ex_rd;
                mac_b   = r_l2_rd;
                mac_acc = r_qe_rd;
            end
            fem_fa_pkg::K_ESX, fem_fa_pkg::K_ESY: begin
                mac_a   = r_qe_rd;
                mac_b   = r_st_rd;
            end
            fem_fa_pkg::K_RPD: begin
                mac_a   = r_esx;
                mac_b   = r_dh1_rd;
                mac_acc = r_rp_rd;
            end
            fem_fa_pkg::K_RPV: begin
                mac_a   = r_esy;
                mac_b   = r_h1_rd;
                mac_acc = r_rp_rd;
            end
            fem_fa_pkg::K_FD: begin
                mac_b   = r_dh1_rd;
            end
            default: ;
        endcase
        if (step.first) begin
            mac_acc = '0;
        end
    end

    fem_fa_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_acc   (mac_acc),
        .o_busy  (mac_busy),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    fem_fa_seq #(
        .QUAD_POINTS (QUAD_POINTS),
        .L2_DOFS     (L2_DOFS),
        .H1_DOFS     (H1_DOFS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (seq_start),
        .i_advance (seq_advance),
        .o_step    (step)
    );

    // write-back
    always_ff @(posedge i_clk) begin
        if (wb && step.kind == fem_fa_pkg::K_EX) begin
            r_ex[step.qx[QW-1:0]] <= mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb && step.kind == fem_fa_pkg::K_QE) begin
            r_qe[step.qx[QW-1:0]][step.qy[QW-1:0]] <= mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb && step.kind == fem_fa_pkg::K_ESX) begin
            r_esx <= mac_res;
        end
        if (wb && step.kind == fem_fa_pkg::K_ESY) begin
            r_esy <= mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb && (step.kind == fem_fa_pkg::K_RPD || step.kind == fem_fa_pkg::K_RPV)) begin
            r_rp[rp_sel][step.dx[HW-1:0]] <= mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb && (step.kind == fem_fa_pkg::K_FY || step.kind == fem_fa_pkg::K_FD)) begin
            r_acc[step.comp][step.dy[HW-1:0]][step.dx[HW-1:0]] <= mac_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dx    <= step.dx;
            r_out_dy    <= step.dy;
            r_out_force <= fem_fa_pkg::sat32(r_acc_rd);
            r_out_comp  <= step.comp;
            r_out_last  <= step.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_force, r_out_dy, r_out_dx};
    assign m_axis_tuser  = r_out_comp;
    assign m_axis_tlast  = r_out_last;

    `FFA_ASSERT(a_ready_unit_quiet, i_clk, i_rst_n, s_axis_tready, !mac_busy)
    `FFA_ASSERT(a_idle_seq_idle, i_clk, i_rst_n, r_state == ST_IDLE, step.kind == fem_fa_pkg::K_IDLE)
    `FFA_ASSERT(a_done_in_wait, i_clk, i_rst_n, mac_done, r_state == ST_WAIT)

endmodule

// ===== tb/fem_force_checker.sv =====
// ---------------------------------------------------------------------------
// fem_force_checker
// Watches both stream channels of fem_force_apply_2d. It mirrors the table
// loads, predicts every force item of a compute and compares each output
// item field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fem_force_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // index_a, index_b, stress_row, stress_col, load_value
    input  logic [2:0]  i_s_tuser,   // req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // dof_x, dof_y, force_value, pad
    input  logic [0:0]  i_m_tuser,   // component
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending,
    output int          o_forces_seen
);

    localparam int QP = fem_fa_pkg::QUAD_POINTS_DEF;
    localparam int LD = fem_fa_pkg::L2_DOFS_DEF;
    localparam int HD = fem_fa_pkg::H1_DOFS_DEF;

    typedef struct {
        logic              comp;
        logic [2:0]        dx;
        logic [2:0]        dy;
        logic signed [31:0] force_val;
        logic              last;
    } t_force_item;

    logic signed [31:0] l2_tab   [QP][LD];
    logic signed [31:0] h1_tab   [QP][HD];
    logic signed [31:0] dh1_tab  [QP][HD];
    logic signed [31:0] edof_tab [LD][LD];
    logic signed [31:0] str_tab  [2][2][QP][QP];

    t_force_item force_q[$];

    initial begin
        o_errors      = 0;
        o_forces_seen = 0;
    end

    assign o_pending = force_q.size();

    function automatic logic signed [47:0] clamp48(input logic signed [95:0] x);
        if (x > 96'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (x < -96'sh8000_0000_0000) return 48'sh8000_0000_0000;
        return x[47:0];
    endfunction

    function automatic logic signed [47:0] mul_round(input logic signed [47:0] a,
                                                     input logic signed [31:0] b);
        logic signed [95:0] p;
        p = a * b;
        p = (p + 96'sd32768) >>> 16;
        return clamp48(p);
    endfunction

    function automatic logic signed [47:0] add_sat(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
        logic signed [95:0] s;
        s = a;
        s = s + b;
        return clamp48(s);
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_errors++;
    endtask

    task automatic predict_forces();
        logic signed [47:0] ex [QP];
        logic signed [47:0] qe [QP][QP];
        logic signed [47:0] rpd [HD];
        logic signed [47:0] rpv [HD];
        logic signed [47:0] acc [HD][HD];
        logic signed [47:0] esx, esy, wide;
        t_force_item fi;
        int n;
        n = 0;
        foreach (qe[a, b]) qe[a][b] = '0;
        for (int dy = 0; dy < LD; dy++) begin
            foreach (ex[q]) ex[q] = '0;
            for (int dx = 0; dx < LD; dx++)
                for (int q = 0; q < QP; q++)
                    ex[q] = add_sat(ex[q], mul_round(edof_tab[dx][dy], l2_tab[q][dx]));
            for (int qy = 0; qy < QP; qy++)
                for (int qx = 0; qx < QP; qx++)
                    qe[qx][qy] = add_sat(qe[qx][qy], mul_round(ex[qx], l2_tab[qy][dy]));
        end
        for (int c = 0; c < 2; c++) begin
            foreach (acc[a, b]) acc[a][b] = '0;
            for (int qy = 0; qy < QP; qy++) begin
                foreach (rpd[d]) begin
                    rpd[d] = '0;
                    rpv[d] = '0;
                end
                for (int qx = 0; qx < QP; qx++) begin
                    esx = mul_round(qe[qx][qy], str_tab[0][c][qx][qy]);
                    esy = mul_round(qe[qx][qy], str_tab[1][c][qx][qy]);
                    for (int d = 0; d < HD; d++) begin
                        rpd[d] = add_sat(rpd[d], mul_round(esx, dh1_tab[qx][d]));
                        rpv[d] = add_sat(rpv[d], mul_round(esy, h1_tab[qx][d]));
                    end
                end
                for (int dy = 0; dy < HD; dy++)
                    for (int dx = 0; dx < HD; dx++) begin
                        acc[dy][dx] = add_sat(acc[dy][dx], mul_round(rpd[dx], h1_tab[qy][dy]));
                        acc[dy][dx] = add_sat(acc[dy][dx], mul_round(rpv[dx], dh1_tab[qy][dy]));
                    end
            end
            for (int dy = 0; dy < HD; dy++)
                for (int dx = 0; dx < HD; dx++) begin
                    wide = acc[dy][dx];
                    fi.comp = c[0];
                    fi.dx   = dx[2:0];
                    fi.dy   = dy[2:0];
                    if (wide > 48'sd2147483647) fi.force_val = 32'sh7FFF_FFFF;
                    else if (wide < -48'sd2147483648) fi.force_val = 32'sh8000_0000;
                    else fi.force_val = wide[31:0];
                    n++;
                    fi.last = (n == 2 * HD * HD);
                    force_q.push_back(fi);
                end
        end
    endtask

    task automatic take_load(input logic [2:0] req, input logic [39:0] d);
        logic [2:0] ia, ib;
        logic       row, col;
        logic signed [31:0] v;
        ia  = d[2:0];
        ib  = d[5:3];
        row = d[6];
        col = d[7];
        v   = d[39:8];
        case (req)
            fem_fa_pkg::REQ_L2:      if (ia < QP && ib < LD) l2_tab[ia][ib] = v;
            fem_fa_pkg::REQ_H1:      if (ia < QP && ib < HD) h1_tab[ia][ib] = v;
            fem_fa_pkg::REQ_DH1:     if (ia < QP && ib < HD) dh1_tab[ia][ib] = v;
            fem_fa_pkg::REQ_EDOF:    if (ia < LD && ib < LD) edof_tab[ia][ib] = v;
            fem_fa_pkg::REQ_STRESS:  if (ia < QP && ib < QP) str_tab[row][col][ia][ib] = v;
            fem_fa_pkg::REQ_COMPUTE: predict_forces();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_force_item e;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            take_load(i_s_tuser, i_s_tdata);
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            o_forces_seen++;
            if (force_q.size() == 0) begin
                report("force item with nothing expected");
            end else begin
                e = force_q.pop_front();
                if (i_m_tuser[0] !== e.comp)
                    report($sformatf("component %0b want %0b", i_m_tuser[0], e.comp));
                if (i_m_tdata[2:0] !== e.dx)
                    report($sformatf("dof_x %0d want %0d", i_m_tdata[2:0], e.dx));
                if (i_m_tdata[5:3] !== e.dy)
                    report($sformatf("dof_y %0d want %0d", i_m_tdata[5:3], e.dy));
                if (i_m_tdata[37:6] !== e.force_val)
                    report($sformatf("force c%0d (%0d,%0d) %h want %h", e.comp, e.dx,
                                     e.dy, i_m_tdata[37:6], e.force_val));
                if (i_m_tlast !== e.last)
                    report($sformatf("last %0b want %0b", i_m_tlast, e.last));
            end
        end
    end

endmodule

// ===== tb/tb_fem_force_apply_2d.sv =====
// ---------------------------------------------------------------------------
// tb_fem_force_apply_2d
// Drives table loads and compute items into fem_force_apply_2d with random
// idle bursts on both channels; the checker predicts and compares forces.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fem_force_apply_2d;

    localparam int QP        = fem_fa_pkg::QUAD_POINTS_DEF;
    localparam int LD        = fem_fa_pkg::L2_DOFS_DEF;
    localparam int HD        = fem_fa_pkg::H1_DOFS_DEF;
    localparam int N_ITEMS   = 370;
    localparam int WDOG_MAX  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int errors, pending, forces_seen;
    int items_sent, computes_sent, idle_cycles;
    bit quiet;
    int rdy_cnt;

    always #5 i_clk = ~i_clk;

    fem_force_apply_2d dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    fem_force_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_forces_seen(forces_seen)
    );

    // output back-pressure in bursts
    always @(posedge i_clk) begin
        if (rdy_cnt > 0) begin
            rdy_cnt <= rdy_cnt - 1;
        end else if (quiet || $urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            rdy_cnt       <= $urandom_range(1, 20);
        end else begin
            m_axis_tready <= 1'b0;
            rdy_cnt       <= $urandom_range(0, 11);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired, %0d forces still expected", pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] rand_val();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
        if (r < 9) return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    task automatic send(input logic [2:0] req, input int unsigned ia, input int unsigned ib,
                        input int unsigned row, input int unsigned col,
                        input logic [31:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {val, col[0], row[0], ib[2:0], ia[2:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (req == fem_fa_pkg::REQ_COMPUTE) computes_sent++;
    endtask

    task automatic load_all_tables();
        for (int q = 0; q < QP; q++) begin
            for (int d = 0; d < LD; d++) send(fem_fa_pkg::REQ_L2, q, d, 0, 0, rand_val());
            for (int d = 0; d < HD; d++) send(fem_fa_pkg::REQ_H1, q, d, 0, 0, rand_val());
            for (int d = 0; d < HD; d++) send(fem_fa_pkg::REQ_DH1, q, d, 0, 0, rand_val());
        end
        for (int x = 0; x < LD; x++)
            for (int y = 0; y < LD; y++) send(fem_fa_pkg::REQ_EDOF, x, y, 0, 0, rand_val());
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                for (int x = 0; x < QP; x++)
                    for (int y = 0; y < QP; y++)
                        send(fem_fa_pkg::REQ_STRESS, x, y, r, c, rand_val());
    endtask

    initial begin
        int r;
        logic [2:0] req;
        items_sent    = 0;
        computes_sent = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        rdy_cnt       = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= fem_fa_pkg::REQ_L2;
        m_axis_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_all_tables();
        send(fem_fa_pkg::REQ_COMPUTE, 0, 0, 0, 0, rand_val());

        // extremes, ignored loads and unknown request codes
        send(fem_fa_pkg::REQ_EDOF, 0, 0, 0, 0, 32'h7FFF_FFFF);
        send(fem_fa_pkg::REQ_EDOF, 1, 1, 0, 0, 32'h8000_0000);
        send(fem_fa_pkg::REQ_L2, 0, 0, 0, 0, 32'h7FFF_FFFF);
        send(fem_fa_pkg::REQ_STRESS, 3, 3, 1, 1, 32'h8000_0000);
        send(fem_fa_pkg::REQ_STRESS, 0, 0, 0, 0, 32'h7FFF_FFFF);
        send(fem_fa_pkg::REQ_COMPUTE, 7, 7, 1, 1, 32'hFFFF_FFFF);
        send(fem_fa_pkg::REQ_L2, 7, 1, 0, 0, rand_val());
        send(fem_fa_pkg::REQ_L2, 0, 2, 0, 0, rand_val());
        send(fem_fa_pkg::REQ_H1, 4, 0, 0, 0, rand_val());
        send(fem_fa_pkg::REQ_DH1, 0, 3, 0, 0, rand_val());
        send(fem_fa_pkg::REQ_EDOF, 2, 0, 0, 0, rand_val());
        send(fem_fa_pkg::REQ_STRESS, 5, 6, 1, 0, rand_val());
        send(3'd6, 1, 1, 1, 1, rand_val());
        send(3'd7, 7, 7, 1, 1, 32'hFFFF_FFFF);
        send(fem_fa_pkg::REQ_EDOF, 0, 0, 0, 0, 32'h0001_0000);
        send(fem_fa_pkg::REQ_EDOF, 1, 1, 0, 0, 32'h0000_0000);
        send(fem_fa_pkg::REQ_L2, 0, 0, 0, 0, 32'h0000_8000);
        send(fem_fa_pkg::REQ_STRESS, 3, 3, 1, 1, 32'h0000_0001);
        send(fem_fa_pkg::REQ_STRESS, 0, 0, 0, 0, 32'hFFFF_0000);
        send(fem_fa_pkg::REQ_COMPUTE, 0, 0, 0, 0, 32'h0);

        while (items_sent < N_ITEMS) begin
            if (items_sent >= N_ITEMS - 60) quiet = 1'b1;
            if (items_sent > 200 && items_sent < 210) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 7) begin
                send(fem_fa_pkg::REQ_COMPUTE, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
            end else if (r < 10) begin
                req = 3'($urandom_range(6, 7));
                send(req, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 20) begin
                req = 3'($urandom_range(0, 4));
                send(req, $urandom, $urandom, $urandom, $urandom, rand_val());
            end else begin
                case ($urandom_range(0, 4))
                    0: send(fem_fa_pkg::REQ_L2, $urandom_range(0, QP-1),
                            $urandom_range(0, LD-1), $urandom, $urandom, rand_val());
                    1: send(fem_fa_pkg::REQ_H1, $urandom_range(0, QP-1),
                            $urandom_range(0, HD-1), $urandom, $urandom, rand_val());
                    2: send(fem_fa_pkg::REQ_DH1, $urandom_range(0, QP-1),
                            $urandom_range(0, HD-1), $urandom, $urandom, rand_val());
                    3: send(fem_fa_pkg::REQ_EDOF, $urandom_range(0, LD-1),
                            $urandom_range(0, LD-1), $urandom, $urandom, rand_val());
                    default: send(fem_fa_pkg::REQ_STRESS, $urandom_range(0, QP-1),
                                  $urandom_range(0, QP-1), $urandom, $urandom, rand_val());
                endcase
            end
        end
        send(fem_fa_pkg::REQ_COMPUTE, 0, 0, 0, 0, 32'h0);
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d items including %0d computes; checked %0d force items.",
                 items_sent, computes_sent, forces_seen);
        $display("Covered value extremes, ignored loads, unknown codes and idle bursts.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
